FILE: design/bslp_pkg.sv
// shared types, codes and helpers for the scan line parser
package bslp_pkg;

    localparam int PREFIX_LEN        = 8;
    localparam int DEF_MAX_PAYLOAD   = 31;
    localparam int COUNT_W           = 5;
    localparam int ADDR_W            = 48;
    localparam int RSSI_W            = 10;
    localparam int STRENGTH_W        = 11;
    localparam logic [RSSI_W-1:0] RSSI_LIMIT = 10'd999;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] F_ADDR    = 3'd0;
    localparam logic [2:0] F_RSSI    = 3'd1;
    localparam logic [2:0] F_ADV     = 3'd2;
    localparam logic [2:0] F_RSP     = 3'd3;
    localparam logic [2:0] F_KIND    = 3'd4;
    localparam logic [2:0] F_DONE    = 3'd5;

    localparam logic [1:0] PH_LENGTH    = 2'd0;
    localparam logic [1:0] PH_TYPE      = 2'd1;
    localparam logic [1:0] PH_UUID_LOW  = 2'd2;
    localparam logic [1:0] PH_UUID_HIGH = 2'd3;

    localparam logic CFG_PREFIX = 1'b0;
    localparam logic CFG_WANTED = 1'b1;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  remaining;
        logic        found;
        logic [15:0] uuid;
    } t_walk;

    typedef struct packed {
        logic                  is_scan_line;
        logic                  service_found;
        logic [15:0]           service_uuid;
        logic [ADDR_W-1:0]     device_address;
        logic [STRENGTH_W-1:0] signal_strength;
        logic [3:0]            address_kind;
        logic [COUNT_W-1:0]    adv_byte_count;
        logic [COUNT_W-1:0]    rsp_byte_count;
    } t_result;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: design/bslp_walk.sv
// advertising record walker: next walk state for one decoded byte
module bslp_walk
    import bslp_pkg::*;
(
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_wanted,
    input  t_walk      i_cur,
    output t_walk      o_nxt
);

    always_comb begin
        o_nxt = i_cur;
        if (i_en && !i_cur.found) begin
            unique case (i_cur.phase)
                PH_LENGTH: begin
                    if (i_cur.remaining != 8'd0) begin
                        o_nxt.remaining = i_cur.remaining - 8'd1;
                    end else if (i_byte != 8'd0) begin
                        o_nxt.remaining = i_byte - 8'd1;
                        o_nxt.phase     = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_byte == i_wanted && i_cur.remaining >= 8'd2) begin
                        o_nxt.phase = PH_UUID_LOW;
                    end else begin
                        o_nxt.phase = PH_LENGTH;
                    end
                end
                PH_UUID_LOW: begin
                    o_nxt.uuid      = {8'd0, i_byte};
                    o_nxt.remaining = i_cur.remaining - 8'd1;
                    o_nxt.phase     = PH_UUID_HIGH;
                end
                PH_UUID_HIGH: begin
                    o_nxt.uuid      = {i_byte, i_cur.uuid[7:0]};
                    o_nxt.remaining = i_cur.remaining - 8'd1;
                    o_nxt.found     = 1'b1;
                    o_nxt.phase     = PH_LENGTH;
                end
                default: o_nxt = i_cur;
            endcase
        end
    end

endmodule

FILE: design/bslp_parse.sv
// line state registers and per-character update, result composition
module bslp_parse
    import bslp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_end,
    input  logic [7:0]  i_char,
    input  logic [63:0] i_prefix,
    input  logic [7:0]  i_wanted,
    output t_result     o_result
);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_PAYLOAD_BYTES > 31) ? 31 : MAX_PAYLOAD_BYTES);

    logic [3:0]          r_prefix_pos, n_prefix_pos;
    logic                r_mismatch, n_mismatch;
    logic [2:0]          r_field, n_field;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [RSSI_W-1:0]   r_rssi, n_rssi;
    logic [3:0]          r_high, n_high;
    logic                r_pending, n_pending;
    logic [COUNT_W-1:0]  r_adv, n_adv;
    logic [COUNT_W-1:0]  r_rsp, n_rsp;
    t_walk               r_walk, w_walk_nxt;
    logic [3:0]          r_kind, n_kind;

    logic [5:0]  w_sel;
    logic [7:0]  w_want;
    logic [4:0]  w_hex;
    logic        w_dec;
    logic [3:0]  w_dig;
    logic [13:0] w_rssi_sum;
    logic [7:0]  w_byte;
    logic        w_walk_en;
    logic        w_scan;

    assign w_sel      = {3'd7 - r_prefix_pos[2:0], 3'b000};
    assign w_want     = i_prefix[w_sel +: 8];
    assign w_hex      = hex_decode(i_char);
    assign w_dec      = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_dig      = 4'(i_char - CH_ZERO);
    assign w_rssi_sum = 14'(r_rssi) * 14'd10 + 14'(w_dig);
    assign w_byte     = {r_high, w_hex[3:0]};

    always_comb begin
        n_prefix_pos = r_prefix_pos;
        n_mismatch   = r_mismatch;
        n_field      = r_field;
        n_addr       = r_addr;
        n_rssi       = r_rssi;
        n_high       = r_high;
        n_pending    = r_pending;
        n_adv        = r_adv;
        n_rsp        = r_rsp;
        n_kind       = r_kind;
        w_walk_en    = 1'b0;
        if (!r_prefix_pos[3]) begin
            n_mismatch   = r_mismatch | (i_char != w_want);
            n_prefix_pos = r_prefix_pos + 4'd1;
        end else if (!r_mismatch && r_field < F_DONE) begin
            if (r_field == F_KIND) begin
                n_kind  = w_dec ? w_dig : 4'd0;
                n_field = F_DONE;
            end else if (i_char == CH_COMMA) begin
                n_pending = 1'b0;
                n_high    = 4'd0;
                n_field   = r_field + 3'd1;
            end else if (r_field == F_RSSI) begin
                if (w_dec) begin
                    n_rssi = (w_rssi_sum > 14'(RSSI_LIMIT)) ? RSSI_LIMIT
                                                             : RSSI_W'(w_rssi_sum);
                end
            end else if (w_hex[4]) begin
                if (r_field == F_ADDR) begin
                    n_addr = {r_addr[ADDR_W-5:0], w_hex[3:0]};
                end else if (!r_pending) begin
                    n_high    = w_hex[3:0];
                    n_pending = 1'b1;
                end else begin
                    n_pending = 1'b0;
                    if (r_field == F_ADV) begin
                        if (r_adv < COUNT_LIMIT) begin
                            n_adv     = r_adv + 1'b1;
                            w_walk_en = 1'b1;
                        end
                    end else if (r_rsp < COUNT_LIMIT) begin
                        n_rsp = r_rsp + 1'b1;
                    end
                end
            end
        end
    end

    bslp_walk u_walk (
        .i_en     (w_walk_en),
        .i_byte   (w_byte),
        .i_wanted (i_wanted),
        .i_cur    (r_walk),
        .o_nxt    (w_walk_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_prefix_pos <= 4'd0;
            r_mismatch   <= 1'b0;
            r_field      <= F_ADDR;
            r_addr       <= '0;
            r_rssi       <= '0;
            r_high       <= 4'd0;
            r_pending    <= 1'b0;
            r_adv        <= '0;
            r_rsp        <= '0;
            r_walk       <= '{phase: PH_LENGTH, remaining: 8'd0, found: 1'b0, uuid: 16'd0};
            r_kind       <= 4'd0;
        end else if (i_step) begin
            r_prefix_pos <= n_prefix_pos;
            r_mismatch   <= n_mismatch;
            r_field      <= n_field;
            r_addr       <= n_addr;
            r_rssi       <= n_rssi;
            r_high       <= n_high;
            r_pending    <= n_pending;
            r_adv        <= n_adv;
            r_rsp        <= n_rsp;
            r_walk       <= w_walk_nxt;
            r_kind       <= n_kind;
        end
    end

    assign w_scan = r_prefix_pos[3] && !r_mismatch;

    always_comb begin
        o_result = '0;
        if (w_scan) begin
            o_result.is_scan_line    = 1'b1;
            o_result.service_found   = r_walk.found;
            o_result.service_uuid    = r_walk.found ? r_walk.uuid : 16'd0;
            o_result.device_address  = r_addr;
            o_result.signal_strength = STRENGTH_W'(0) - STRENGTH_W'(r_rssi);
            o_result.address_kind    = r_kind;
            o_result.adv_byte_count  = r_adv;
            o_result.rsp_byte_count  = r_rsp;
        end
    end

endmodule

FILE: design/ble_scan_line_parser.sv
// top level of the scan line parser: input register, parser, result register
// One character is taken per cycle. A character passes an input register, the
// parser updates the line state in the following cycle, and a line end passes
// the input register and then loads the result register, from which the result
// is offered. A line end stalls the input only while the result register still
// holds an untaken result. Configuration is written through its own channel,
// which is always ready; write it between lines.
module ble_scan_line_parser
    import bslp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // character
    input  logic        i_s_tlast,   // line_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // service_found, service_uuid, device_address, signal_strength,
    // address_kind, adv_byte_count, rsp_byte_count, zero padding
    output logic [95:0] o_m_tdata,
    output logic        o_m_tuser,   // is_scan_line
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_end;
    logic        r_out_valid;
    t_result     r_out;
    logic [63:0] r_prefix;
    logic [7:0]  r_wanted;

    logic        w_out_free;
    logic        w_step;
    t_result     w_result;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_step      = r_in_valid && (!r_in_end || w_out_free);
    assign o_s_tready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 64'd0;
            r_wanted <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PREFIX: r_prefix <= i_cfg_data;
                CFG_WANTED: r_wanted <= i_cfg_data[7:0];
                default:    r_wanted <= r_wanted;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    bslp_parse #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_end    (r_in_end),
        .i_char   (r_in_char),
        .i_prefix (r_prefix),
        .i_wanted (r_wanted),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_end) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.is_scan_line;
    assign o_m_tdata  = {6'd0, r_out.rsp_byte_count, r_out.adv_byte_count,
                         r_out.address_kind, r_out.signal_strength,
                         r_out.device_address, r_out.service_uuid,
                         r_out.service_found};

endmodule

FILE: sim/ble_scan_line_parser_test.sv
// self-checking testbench for the scan line parser: scan line stimulus, predicted reports
`timescale 1ns / 100ps

module ble_scan_line_parser_test;
    import bslp_pkg::*;

    localparam int COUNT_LIMIT    = (DEF_MAX_PAYLOAD > 31) ? 31 : DEF_MAX_PAYLOAD;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] PREFIX_TEXT = 64'h2B5343414E3A2020;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum int {
        SHAPE_GOOD, SHAPE_LONG_ADDR, SHAPE_SHORT_ADDR, SHAPE_BIG_RSSI, SHAPE_ODD_HEX,
        SHAPE_LONG_ADV, SHAPE_BAD_KIND, SHAPE_EXTRA, SHAPE_RECORDS, SHAPE_BAD_PREFIX,
        SHAPE_SHORT, SHAPE_NOISE, SHAPE_EMPTY
    } line_shape_e;

    class scan_report_tracker;
        logic [63:0] prefix;
        logic [7:0]  wanted;
        int unsigned pos;
        bit          mismatch;
        logic [2:0]  field;
        logic [47:0] addr;
        int unsigned rssi;
        logic [3:0]  hi;
        bit          pend;
        logic [4:0]  adv;
        logic [4:0]  rsp;
        logic [7:0]  remaining;
        logic [1:0]  phase;
        bit          found;
        logic [15:0] uuid;
        logic [3:0]  kind;
        t_result     pending_reports[$];
        int          errors;
        int          lines;
        int          scans;
        int          captures;
        int          chars;

        function new();
            prefix = '0;
            wanted = 8'd3;
            errors = 0;
            lines = 0;
            scans = 0;
            captures = 0;
            chars = 0;
            clear_line();
        endfunction

        function void clear_line();
            pos = 0;
            mismatch = 0;
            field = F_ADDR;
            addr = '0;
            rssi = 0;
            hi = '0;
            pend = 0;
            adv = '0;
            rsp = '0;
            remaining = '0;
            phase = PH_LENGTH;
            found = 0;
            uuid = '0;
            kind = '0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void write_reg(logic idx, logic [63:0] data);
            if (idx == CFG_PREFIX) begin
                prefix = data;
            end else begin
                wanted = data[7:0];
            end
        endfunction

        function void take_input(logic [7:0] c, logic last);
            logic [7:0]  b;
            logic [3:0]  nib;
            bit          is_hex;
            int unsigned v;
            t_result     r;
            if (last) begin
                r = '0;
                if (pos >= PREFIX_LEN && !mismatch) begin
                    r.is_scan_line    = 1'b1;
                    r.service_found   = found;
                    r.service_uuid    = found ? uuid : 16'h0;
                    r.device_address  = addr;
                    r.signal_strength = 11'(2048 - rssi);
                    r.address_kind    = kind;
                    r.adv_byte_count  = adv;
                    r.rsp_byte_count  = rsp;
                    scans++;
                    if (found) captures++;
                end
                pending_reports.push_back(r);
                lines++;
                clear_line();
                return;
            end
            chars++;
            if (pos < PREFIX_LEN) begin
                if (c != prefix[8*(7-pos) +: 8]) mismatch = 1;
                pos++;
                return;
            end
            if (mismatch || field >= F_DONE) return;
            if (field == F_KIND) begin
                kind = (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : 4'd0;
                field = F_DONE;
                return;
            end
            if (c == CH_COMMA) begin
                pend = 0;
                hi = '0;
                field++;
                return;
            end
            if (field == F_RSSI) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    v = rssi * 10 + (c - CH_ZERO);
                    rssi = (v > RSSI_LIMIT) ? RSSI_LIMIT : v;
                end
                return;
            end
            is_hex = 1;
            nib = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                nib = 4'(c - CH_ZERO);
            end else if (c >= 8'h61 && c <= 8'h66) begin
                nib = 4'(c - 8'h61 + 8'd10);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                nib = 4'(c - 8'h41 + 8'd10);
            end else begin
                is_hex = 0;
            end
            if (!is_hex) return;
            if (field == F_ADDR) begin
                addr = {addr[43:0], nib};
                return;
            end
            if (!pend) begin
                hi = nib;
                pend = 1;
                return;
            end
            pend = 0;
            b = {hi, nib};
            if (field == F_ADV) begin
                if (adv < COUNT_LIMIT) begin
                    adv++;
                    // length/type record walk, frozen after the first capture
                    if (!found) begin
                        case (phase)
                            PH_LENGTH: begin
                                if (remaining != 0) begin
                                    remaining--;
                                end else if (b != 0) begin
                                    remaining = b - 8'd1;
                                    phase = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                phase = (b == wanted && remaining >= 2) ? PH_UUID_LOW : PH_LENGTH;
                            end
                            PH_UUID_LOW: begin
                                uuid = {8'h00, b};
                                remaining--;
                                phase = PH_UUID_HIGH;
                            end
                            default: begin
                                uuid[15:8] = b;
                                remaining--;
                                found = 1;
                                phase = PH_LENGTH;
                            end
                        endcase
                    end
                end
            end else if (rsp < COUNT_LIMIT) begin
                rsp++;
            end
        endfunction

        function void compare_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_report(logic tuser, logic [95:0] d);
            t_result got;
            t_result exp_r;
            got.is_scan_line    = tuser;
            got.service_found   = d[0];
            got.service_uuid    = d[16:1];
            got.device_address  = d[64:17];
            got.signal_strength = d[75:65];
            got.address_kind    = d[79:76];
            got.adv_byte_count  = d[84:80];
            got.rsp_byte_count  = d[89:85];
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: report with no line end pending, expected none, actual %h",
                         $time, got);
                return;
            end
            exp_r = pending_reports.pop_front();
            compare_field("is_scan_line", exp_r.is_scan_line, got.is_scan_line);
            compare_field("service_found", exp_r.service_found, got.service_found);
            compare_field("service_uuid", exp_r.service_uuid, got.service_uuid);
            compare_field("device_address", exp_r.device_address, got.device_address);
            compare_field("signal_strength", exp_r.signal_strength, got.signal_strength);
            compare_field("address_kind", exp_r.address_kind, got.address_kind);
            compare_field("adv_byte_count", exp_r.adv_byte_count, got.adv_byte_count);
            compare_field("rsp_byte_count", exp_r.rsp_byte_count, got.rsp_byte_count);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // character
    logic        i_s_tlast;   // line_end
    logic        o_m_tvalid;
    logic        i_m_tready;
    // service_found, service_uuid, device_address, signal_strength,
    // address_kind, adv_byte_count, rsp_byte_count, zero padding
    logic [95:0] o_m_tdata;
    logic        o_m_tuser;   // is_scan_line
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    scan_report_tracker sb;
    logic [7:0]  line_buf[$];
    logic [63:0] cur_prefix;
    logic [7:0]  cur_wanted;
    bit          tx_idle_en;
    bit          rx_stall_en;
    bit          hold_request;
    int          settings_written;

    ble_scan_line_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // every transfer is observed here, config and input before output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) sb.take_input(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_report(o_m_tuser, o_m_tdata);
        end
    end

    initial begin : receiver
        int burst;
        burst = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                burst = LONG_HOLD;
            end
            if (burst > 0) begin
                burst--;
                i_m_tready <= 1'b0;
            end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 12);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stall_count;
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_count = 0;
            end else begin
                stall_count++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ble_scan_line_parser_test failed");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return 8'(CH_ZERO + n);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10);
    endfunction

    task automatic push_hex(logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endtask

    task automatic build_line(line_shape_e shape);
        int         k;
        int         n;
        int         len;
        logic [7:0] adv[$];
        line_buf.delete();
        if (shape == SHAPE_EMPTY) return;
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom));
            return;
        end
        for (k = 0; k < PREFIX_LEN; k++) line_buf.push_back(cur_prefix[8*(7-k) +: 8]);
        if (shape == SHAPE_BAD_PREFIX) begin
            k = $urandom_range(0, 7);
            line_buf[k] = line_buf[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (shape == SHAPE_SHORT) begin
            k = $urandom_range(0, 7);
            while (line_buf.size() > k) void'(line_buf.pop_back());
            return;
        end
        // quoted address
        n = (shape == SHAPE_LONG_ADDR) ? $urandom_range(13, 18) :
            (shape == SHAPE_SHORT_ADDR) ? $urandom_range(0, 11) : 12;
        line_buf.push_back(CH_QUOTE);
        for (k = 0; k < n; k++) begin
            if (k > 0 && k % 2 == 0) line_buf.push_back(CH_COLON);
            line_buf.push_back(hex_char(4'($urandom)));
        end
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(CH_COMMA);
        // rssi
        line_buf.push_back(CH_MINUS);
        n = (shape == SHAPE_BIG_RSSI) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        line_buf.push_back(CH_COMMA);
        // advertising records
        if (shape == SHAPE_RECORDS) begin
            adv = {8'h00, 8'h02, cur_wanted, 8'($urandom), 8'h00, 8'h05, cur_wanted,
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'h03, cur_wanted, 8'($urandom), 8'($urandom)};
        end else begin
            n = (shape == SHAPE_LONG_ADV) ? $urandom_range(32, 40) : $urandom_range(0, 16);
            while (adv.size() < n) begin
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    adv.push_back(8'h00);
                end else begin
                    len = $urandom_range(0, 5);
                    adv.push_back(8'(len + 1));
                    adv.push_back((k < 5) ? cur_wanted : 8'($urandom));
                    repeat (len) adv.push_back(8'($urandom));
                end
            end
            if (adv.size() != 0 && $urandom_range(0, 15) == 0) begin
                adv[$urandom_range(0, adv.size() - 1)] = 8'($urandom);
            end
        end
        foreach (adv[i]) push_hex(adv[i]);
        if (shape == SHAPE_ODD_HEX) line_buf.push_back(hex_char(4'($urandom)));
        line_buf.push_back(CH_COMMA);
        // scan response
        n = (shape == SHAPE_LONG_ADV) ? $urandom_range(32, 40) : $urandom_range(0, 8);
        repeat (n) push_hex(8'($urandom));
        if (shape == SHAPE_ODD_HEX) line_buf.push_back(hex_char(4'($urandom)));
        line_buf.push_back(CH_COMMA);
        // address type and anything after it
        line_buf.push_back((shape == SHAPE_BAD_KIND) ? 8'($urandom) :
                           8'(CH_ZERO + $urandom_range(0, 9)));
        if (shape == SHAPE_EXTRA) begin
            repeat ($urandom_range(1, 12)) begin
                line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : 8'($urandom));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            line_buf.insert($urandom_range(PREFIX_LEN, line_buf.size()), 8'($urandom));
        end
    endtask

    task automatic send_item(logic [7:0] c, logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_line(line_shape_e shape);
        build_line(shape);
        foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    // stop offering and wait for every pending report plus the pipeline tail
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [63:0] pfx, logic [7:0] wnt);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PREFIX;
        i_cfg_data  <= pfx;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_WANTED;
        i_cfg_data  <= {56'd0, wnt};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_prefix = pfx;
        cur_wanted = wnt;
        settings_written++;
    endtask

    initial begin
        int          ph;
        int          k;
        int          lines_here;
        logic [63:0] pfx;
        logic [7:0]  wnt;
        sb = new();
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_PREFIX;
        i_cfg_data   = '0;
        cur_prefix   = '0;
        cur_wanted   = 8'd3;
        tx_idle_en   = 1;
        rx_stall_en  = 1;
        hold_request = 0;
        settings_written = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: a prefix of eight zero-valued bytes
        send_line(SHAPE_GOOD);
        send_line(SHAPE_EMPTY);
        drain();
        write_regs(PREFIX_TEXT, 8'd3);
        send_line(SHAPE_GOOD);
        send_line(SHAPE_RECORDS);
        send_line(SHAPE_BAD_PREFIX);
        send_line(SHAPE_SHORT);
        send_line(SHAPE_LONG_ADDR);
        send_line(SHAPE_SHORT_ADDR);
        send_line(SHAPE_BIG_RSSI);
        send_line(SHAPE_ODD_HEX);
        send_line(SHAPE_LONG_ADV);
        send_line(SHAPE_BAD_KIND);
        send_line(SHAPE_EXTRA);
        send_line(SHAPE_NOISE);

        // output held off while lines keep coming, so line ends back up
        tx_idle_en = 0;
        hold_request = 1;
        repeat (2) send_line(SHAPE_GOOD);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    pfx = '1;
                    wnt = 8'hFF;
                end
                1: begin
                    pfx = '0;
                    wnt = 8'h00;
                end
                2: begin
                    pfx = {$urandom, $urandom};
                    wnt = 8'($urandom);
                end
                3: begin
                    for (k = 0; k < PREFIX_LEN; k++) pfx[8*k +: 8] = 8'($urandom_range(33, 126));
                    wnt = 8'd3;
                end
                default: begin
                    pfx = PREFIX_TEXT;
                    wnt = 8'($urandom);
                end
            endcase
            drain();
            write_regs(pfx, wnt);
            lines_here = 0;
            while (lines_here < 2) begin
                tx_idle_en  = (ph < 4) && ($urandom_range(0, 3) != 0);
                rx_stall_en = (ph < 4) && ($urandom_range(0, 3) != 0);
                k = $urandom_range(0, 24);
                send_line((k >= 12 && k <= 23) ? line_shape_e'(k - 11) : SHAPE_GOOD);
                lines_here++;
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("covered %0d lines (%0d scan lines, %0d uuid captures), %0d characters",
                 sb.lines, sb.scans, sb.captures, sb.chars);
        $display("register settings applied: %0d, mismatches: %0d", settings_written, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ble_scan_line_parser_test passed");
        end else begin
            $display("ble_scan_line_parser_test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/bslp_pkg.sv
design/bslp_walk.sv
design/bslp_parse.sv
design/ble_scan_line_parser.sv
sim/ble_scan_line_parser_test.sv
